>>> hdl/htca_pkg.sv
// shared constants for the humidity and temperature consistency averager
package htca_pkg;

    localparam logic [2:0]  INNER_ATTEMPTS = 3'd5;
    localparam logic [2:0]  OUTER_TRIES    = 3'd5;
    localparam logic [15:0] HUMIDITY_LIMIT = 16'd1000;
    localparam logic [15:0] STEP_RESET     = 16'd100;
    localparam int          TEMP_MAG_W     = 15;
    localparam int          HUM_W          = 10;
    localparam int          IN_DATA_W      = 32;
    localparam int          OUT_DATA_W     = 32;

endpackage

>>> hdl/htca_div.sv
// restoring divider, one quotient bit per cycle, unsigned dividend by small divisor
module htca_div #(
    parameter int DW = 17,
    parameter int KW = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [KW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [KW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;

    logic [KW:0]   rem_sh;
    logic [KW:0]   rem_sub;
    logic          fits;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[DW-1]};
        fits    = rem_sh >= {1'b0, divisor};
        rem_sub = rem_sh - {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? rem_sub[KW-1:0] : rem_sh[KW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hdl/humidity_temp_consistency_averager.sv
// top level: retry bookkeeping, consistency filter, sums and averaging sequencer
//
//  channel  dir  handshake               payload
//  s_*      in   s_tvalid / s_tready     tuser: read_ok; tdata: raw_temperature, raw_humidity
//  m_*      out  m_tvalid / m_tready     tuser: result_valid; tdata: averages, readings_used
//  cfg_*    in   cfg_we                  cfg_wdata: max_step_difference
//
// an item that does not end a session leaves the block idle and ready for the next; an
// item that ends a session with two or more kept pairs passes through a setup state,
// two one-bit-per-cycle divider runs (temperature, then humidity) and the emit state;
// a short session goes straight to the emit state. reset restarts the session and
// sets the step to 100.
// a finished result waits in the output register; only the next session end stalls on it
module humidity_temp_consistency_averager #(
    parameter int READINGS_WANTED = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] raw_temperature, [31:16] raw_humidity
    input  logic        s_tuser,   // [0] read_ok
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] average_temperature, [25:16] average_humidity,
                                   // [27:26] readings_used, [31:28] zero
    output logic        m_tuser,   // [0] result_valid
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam int KCW = $clog2(READINGS_WANTED + 1);
    localparam int TMW = htca_pkg::TEMP_MAG_W + $clog2(READINGS_WANTED);
    localparam int TSW = TMW + 1;
    localparam int HSW = htca_pkg::HUM_W + $clog2(READINGS_WANTED);
    localparam int DW  = TMW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_DIV_T,
        S_DIV_H,
        S_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [15:0]      step_reg, step_next;
    logic [2:0]       inner_reg, inner_next;
    logic [2:0]       outer_reg, outer_next;
    logic [KCW-1:0]   kept_reg, kept_next;
    logic [TSW-1:0]   tsum_reg, tsum_next;
    logic [HSW-1:0]   hsum_reg, hsum_next;
    logic [15:0]      last_t_reg, last_t_next;
    logic [9:0]       last_h_reg, last_h_next;
    logic [15:0]      avg_t_reg, avg_t_next;
    logic [9:0]       avg_h_reg, avg_h_next;
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      m_data_reg, m_data_next;
    logic             m_user_reg, m_user_next;

    logic             accept;
    logic             read_ok;
    logic [15:0]      raw_t;
    logic [15:0]      raw_h;
    logic [16:0]      temp_in;
    logic [16:0]      dt;
    logic [16:0]      adt;
    logic [10:0]      dh;
    logic [10:0]      adh;
    logic             hum_ok;
    logic             keep;
    logic             try_used;
    logic [2:0]       outer_dec;
    logic [KCW-1:0]   kept_inc;
    logic             finish;
    logic [TMW-1:0]   tsum_mag;
    logic [15:0]      qt_signed;

    logic             div_start;
    logic [DW-1:0]    div_dividend;
    logic             div_done;
    logic [DW-1:0]    div_quotient;

    htca_div #(
        .DW (DW),
        .KW (KCW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (kept_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign read_ok  = s_tuser;
    assign raw_t    = s_tdata[15:0];
    assign raw_h    = s_tdata[31:16];

    // filter and counters for one read attempt
    always_comb
    begin
        temp_in = raw_t[15] ? (17'd0 - {2'b00, raw_t[14:0]}) : {2'b00, raw_t[14:0]};
        dt      = temp_in - {last_t_reg[15], last_t_reg};
        adt     = dt[16] ? (17'd0 - dt) : dt;
        dh      = {1'b0, raw_h[9:0]} - {1'b0, last_h_reg};
        adh     = dh[10] ? (11'd0 - dh) : dh;
        hum_ok  = raw_h <= htca_pkg::HUMIDITY_LIMIT;
        keep    = read_ok && hum_ok &&
                  ((kept_reg == '0) ||
                   ((adt < {1'b0, step_reg}) && ({5'd0, adh} < step_reg)));
        try_used  = read_ok || (inner_reg == 3'd1) || (inner_reg == 3'd0);
        outer_dec = (outer_reg != 3'd0) ? (outer_reg - 3'd1) : outer_reg;
        kept_inc  = kept_reg + KCW'(keep);
        finish    = try_used &&
                    ((kept_inc >= KCW'(READINGS_WANTED)) || (outer_dec == 3'd0));
        tsum_mag  = tsum_reg[TSW-1] ? TMW'(0 - tsum_reg) : tsum_reg[TMW-1:0];
        qt_signed = tsum_reg[TSW-1] ? (16'd0 - div_quotient[15:0]) : div_quotient[15:0];
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = cfg_we ? cfg_wdata : step_reg;
        inner_next   = inner_reg;
        outer_next   = outer_reg;
        kept_next    = kept_reg;
        tsum_next    = tsum_reg;
        hsum_next    = hsum_reg;
        last_t_next  = last_t_reg;
        last_h_next  = last_h_reg;
        avg_t_next   = avg_t_reg;
        avg_h_next   = avg_h_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        div_start    = 1'b0;
        div_dividend = tsum_mag;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (read_ok || inner_reg == 3'd1 || inner_reg == 3'd0)
                    begin
                        inner_next = htca_pkg::INNER_ATTEMPTS;
                    end
                    else
                    begin
                        inner_next = inner_reg - 3'd1;
                    end
                    if (try_used)
                    begin
                        outer_next = outer_dec;
                    end
                    if (keep)
                    begin
                        kept_next   = kept_inc;
                        tsum_next   = tsum_reg + {{(TSW-17){temp_in[16]}}, temp_in};
                        hsum_next   = hsum_reg + {{(HSW-10){1'b0}}, raw_h[9:0]};
                        last_t_next = temp_in[15:0];
                        last_h_next = raw_h[9:0];
                    end
                    if (finish)
                    begin
                        if (kept_inc > KCW'(1))
                        begin
                            state_next = S_SETUP;
                        end
                        else
                        begin
                            avg_t_next = '0;
                            avg_h_next = '0;
                            state_next = S_EMIT;
                        end
                    end
                end
            end
            S_SETUP:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_T;
            end
            S_DIV_T:
            begin
                if (div_done)
                begin
                    avg_t_next   = qt_signed;
                    div_start    = 1'b1;
                    div_dividend = {{(DW-HSW){1'b0}}, hsum_reg};
                    state_next   = S_DIV_H;
                end
            end
            S_DIV_H:
            begin
                if (div_done)
                begin
                    avg_h_next = div_quotient[9:0];
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'd0, kept_reg[1:0], avg_h_reg, avg_t_reg};
                    m_user_next  = kept_reg > KCW'(1);
                    inner_next   = htca_pkg::INNER_ATTEMPTS;
                    outer_next   = htca_pkg::OUTER_TRIES;
                    kept_next    = '0;
                    tsum_next    = '0;
                    hsum_next    = '0;
                    last_t_next  = '0;
                    last_h_next  = '0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            step_reg    <= htca_pkg::STEP_RESET;
            inner_reg   <= htca_pkg::INNER_ATTEMPTS;
            outer_reg   <= htca_pkg::OUTER_TRIES;
            kept_reg    <= '0;
            tsum_reg    <= '0;
            hsum_reg    <= '0;
            last_t_reg  <= '0;
            last_h_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            inner_reg   <= inner_next;
            outer_reg   <= outer_next;
            kept_reg    <= kept_next;
            tsum_reg    <= tsum_next;
            hsum_reg    <= hsum_next;
            last_t_reg  <= last_t_next;
            last_h_reg  <= last_h_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_t_reg  <= avg_t_next;
        avg_h_reg  <= avg_h_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
